### design/smj_pkg.sv
// Package for the sort-merge join engine.
// Holds default sizes, operation, predicate, mode and phase codes.
// No dependencies.
package smj_pkg;

  localparam int DEPTH    = 1024;
  localparam int KEY_BITS = 32;
  localparam int ROW_BITS = 32;

  localparam int IN_ROW_W  = 32;
  localparam int IN_KEY_W  = 32;
  localparam int OUT_ROW_W = 32;
  localparam int CFG_W     = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_LOAD_L = 2'd1;
  localparam logic [1:0] OP_LOAD_R = 2'd2;
  localparam logic [1:0] OP_FETCH  = 2'd3;

  localparam logic [2:0] CMP_EQ = 3'd0;
  localparam logic [2:0] CMP_LT = 3'd1;
  localparam logic [2:0] CMP_GT = 3'd2;
  localparam logic [2:0] CMP_LE = 3'd3;
  localparam logic [2:0] CMP_GE = 3'd4;

  localparam logic [1:0] MODE_INNER = 2'd0;
  localparam logic [1:0] MODE_LEFT  = 2'd1;
  localparam logic [1:0] MODE_RIGHT = 2'd2;
  localparam logic [1:0] MODE_FULL  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_OP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JOIN_MODE  = 2'd1;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SELECT = 3'd1;
  localparam logic [2:0] PH_CROSS  = 3'd2;
  localparam logic [2:0] PH_LNULL  = 3'd3;
  localparam logic [2:0] PH_RNULL  = 3'd4;
  localparam logic [2:0] PH_TAILR  = 3'd5;
  localparam logic [2:0] PH_TAILL  = 3'd6;
  localparam logic [2:0] PH_DONE   = 3'd7;

endpackage

### design/smj_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module smj_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/sort_merge_join_engine.sv
// Sort-merge join engine over two key-sorted tables held in two RAMs.
// Depends on smj_pkg and smj_ram.
//
// Loads and clears are accepted back to back. A fetch walks a sequencer around
// one read port per table. A fetch whose pair is ready at the cursors is
// accepted, then evaluates the join phase while reading both rows, then loads
// the result register once it is free. Every change of join phase adds another
// evaluation. Bounding a run reads its first key and then compares each
// following row in turn until a key differs or the table ends; a side whose run
// starts past its row count is bounded without a read, and the scan then
// returns to evaluation. A result sits in an output register, so the next
// transaction is taken while it waits. There is no clearing pass after reset.
module sort_merge_join_engine #(
  parameter int DEPTH    = smj_pkg::DEPTH,
  parameter int KEY_BITS = smj_pkg::KEY_BITS,
  parameter int ROW_BITS = smj_pkg::ROW_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // row_id [31:0], key [63:32]
  input  logic [1:0]  in_tuser,   // operation [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // left_row, left_is_null, right_row, right_is_null, zeros
  output logic        out_tlast,  // end_of_join
  input  logic        cfg_wen,
  input  logic [smj_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smj_pkg::CFG_W-1:0]     cfg_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = KEY_BITS + ROW_BITS;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_K0   = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_CMP  = 3'd5;
  localparam logic [2:0] S_ROW  = 3'd6;

  logic [2:0] st_r, st_nxt, jph_r, jph_nxt;
  logic [2:0] cmp_r;
  logic [1:0] mode_r;
  logic [CW-1:0] lcnt_r, lcnt_nxt, rcnt_r, rcnt_nxt;
  logic [CW-1:0] lb_r, lb_nxt, ls_r, ls_nxt, rb_r, rb_nxt, rs_r, rs_nxt;
  logic [CW-1:0] oc_r, oc_nxt, ic_r, ic_nxt, e_r, e_nxt;
  logic signed [KEY_BITS-1:0] lk_r, lk_nxt, rk_r, rk_nxt;
  logic scan_l_r, scan_l_nxt, scan_r_r, scan_r_nxt;
  logic em_ln_r, em_ln_nxt, em_rn_r, em_rn_nxt, em_end_r, em_end_nxt;
  logic out_tvalid_r, out_tvalid_nxt;
  logic [71:0] out_tdata_r, out_tdata_nxt;
  logic out_tlast_r, out_tlast_nxt;

  logic l_we, r_we;
  logic [AW-1:0] l_raddr, r_raddr;
  logic [MW-1:0] l_rdata, r_rdata, wdata;

  logic c_hit;
  logic [CW-1:0] c_oa, c_ob, c_ia, c_ib;
  logic lmode, rmode, is_eq, key_lt, key_gt;
  logic accept;
  logic [CW-1:0] s_beg, s_cnt;
  logic signed [KEY_BITS-1:0] s_key, s_rkey;

  assign in_tready  = (st_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  assign wdata = {ROW_BITS'($unsigned(in_tdata[31:0])), KEY_BITS'($unsigned(in_tdata[63:32]))};
  assign l_we  = accept && (in_tuser == smj_pkg::OP_LOAD_L) && (lcnt_r < DEPTH_C);
  assign r_we  = accept && (in_tuser == smj_pkg::OP_LOAD_R) && (rcnt_r < DEPTH_C);

  always_comb begin
    l_raddr = oc_r[AW-1:0];
    r_raddr = ic_r[AW-1:0];
    if (st_r == S_SCAN) begin
      l_raddr = lb_r[AW-1:0];
      r_raddr = rb_r[AW-1:0];
    end else if (st_r == S_CHK) begin
      l_raddr = e_r[AW-1:0];
      r_raddr = e_r[AW-1:0];
    end
  end

  smj_ram #(.WIDTH(MW), .DEPTH(DEPTH), .AW(AW)) u_left_ram (
    .clk(clk), .we(l_we), .waddr(lcnt_r[AW-1:0]), .wdata(wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  smj_ram #(.WIDTH(MW), .DEPTH(DEPTH), .AW(AW)) u_right_ram (
    .clk(clk), .we(r_we), .waddr(rcnt_r[AW-1:0]), .wdata(wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  assign lmode  = (mode_r == smj_pkg::MODE_LEFT) || (mode_r == smj_pkg::MODE_FULL);
  assign rmode  = (mode_r == smj_pkg::MODE_RIGHT) || (mode_r == smj_pkg::MODE_FULL);
  assign is_eq  = (cmp_r == smj_pkg::CMP_EQ);
  assign key_lt = lk_r < rk_r;
  assign key_gt = lk_r > rk_r;

  always_comb begin
    c_oa  = lb_r;
    c_ob  = ls_r;
    c_ia  = rb_r;
    c_ib  = rs_r;
    c_hit = 1'b0;
    case (cmp_r)
      smj_pkg::CMP_EQ: c_hit = !key_lt && !key_gt;
      smj_pkg::CMP_LT: begin
        c_ib = rcnt_r;
        if (!key_lt && !key_gt) begin
          c_ia  = rs_r;
          c_hit = 1'b1;
        end else begin
          c_hit = key_lt;
        end
      end
      smj_pkg::CMP_GT: begin
        c_ob = lcnt_r;
        if (!key_lt && !key_gt) begin
          c_oa  = ls_r;
          c_hit = 1'b1;
        end else begin
          c_hit = key_gt;
        end
      end
      smj_pkg::CMP_LE: begin
        c_ib  = rcnt_r;
        c_hit = !key_gt;
      end
      smj_pkg::CMP_GE: begin
        c_ob  = lcnt_r;
        c_hit = !key_lt;
      end
      default: c_hit = 1'b0;
    endcase
  end

  assign s_beg  = scan_l_r ? lb_r : rb_r;
  assign s_cnt  = scan_l_r ? lcnt_r : rcnt_r;
  assign s_key  = scan_l_r ? lk_r : rk_r;
  assign s_rkey = scan_l_r ? l_rdata[KEY_BITS-1:0] : r_rdata[KEY_BITS-1:0];

  always_comb begin
    st_nxt = st_r;  jph_nxt = jph_r;
    lcnt_nxt = lcnt_r;  rcnt_nxt = rcnt_r;
    lb_nxt = lb_r;  ls_nxt = ls_r;  rb_nxt = rb_r;  rs_nxt = rs_r;
    oc_nxt = oc_r;  ic_nxt = ic_r;  e_nxt = e_r;
    lk_nxt = lk_r;  rk_nxt = rk_r;
    scan_l_nxt = scan_l_r;  scan_r_nxt = scan_r_r;
    em_ln_nxt = em_ln_r;  em_rn_nxt = em_rn_r;  em_end_nxt = em_end_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;

    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            smj_pkg::OP_CLEAR: begin
              lcnt_nxt = '0;
              rcnt_nxt = '0;
              jph_nxt  = smj_pkg::PH_IDLE;
            end
            smj_pkg::OP_LOAD_L: begin
              if (l_we) begin
                lcnt_nxt = lcnt_r + ONE_C;
              end
              jph_nxt = smj_pkg::PH_IDLE;
            end
            smj_pkg::OP_LOAD_R: begin
              if (r_we) begin
                rcnt_nxt = rcnt_r + ONE_C;
              end
              jph_nxt = smj_pkg::PH_IDLE;
            end
            default: st_nxt = S_EVAL;
          endcase
        end
        if (cfg_wen && (cfg_index == smj_pkg::REG_COMPARE_OP ||
                        cfg_index == smj_pkg::REG_JOIN_MODE)) begin
          jph_nxt = smj_pkg::PH_IDLE;
        end
      end
      S_EVAL: begin
        em_ln_nxt  = 1'b0;
        em_rn_nxt  = 1'b0;
        em_end_nxt = 1'b0;
        case (jph_r)
          smj_pkg::PH_IDLE: begin
            lb_nxt = '0;
            rb_nxt = '0;
            scan_l_nxt = 1'b1;
            scan_r_nxt = 1'b1;
            jph_nxt = smj_pkg::PH_SELECT;
            st_nxt  = S_SCAN;
          end
          smj_pkg::PH_SELECT: begin
            if (lb_r < lcnt_r && rb_r < rcnt_r) begin
              if (c_hit) begin
                oc_nxt  = c_oa;
                ic_nxt  = c_ia;
                jph_nxt = smj_pkg::PH_CROSS;
              end else if (is_eq && key_lt && lmode) begin
                oc_nxt  = lb_r;
                jph_nxt = smj_pkg::PH_LNULL;
              end else if (is_eq && key_gt && rmode) begin
                ic_nxt  = rb_r;
                jph_nxt = smj_pkg::PH_RNULL;
              end else begin
                if (!key_gt) begin
                  lb_nxt = ls_r;
                  scan_l_nxt = 1'b1;
                end
                if (!key_lt) begin
                  rb_nxt = rs_r;
                  scan_r_nxt = 1'b1;
                end
                st_nxt = S_SCAN;
              end
            end else if (lb_r >= lcnt_r && is_eq && rmode) begin
              ic_nxt  = rb_r;
              jph_nxt = smj_pkg::PH_TAILR;
            end else if (rb_r >= rcnt_r && is_eq && lmode) begin
              oc_nxt  = lb_r;
              jph_nxt = smj_pkg::PH_TAILL;
            end else begin
              jph_nxt = smj_pkg::PH_DONE;
            end
          end
          smj_pkg::PH_CROSS, smj_pkg::PH_LNULL, smj_pkg::PH_RNULL: begin
            if ((jph_r == smj_pkg::PH_CROSS && (oc_r >= c_ob || c_ia >= c_ib)) ||
                (jph_r == smj_pkg::PH_LNULL && oc_r >= ls_r) ||
                (jph_r == smj_pkg::PH_RNULL && ic_r >= rs_r)) begin
              if (!key_gt) begin
                lb_nxt = ls_r;
                scan_l_nxt = 1'b1;
              end
              if (!key_lt) begin
                rb_nxt = rs_r;
                scan_r_nxt = 1'b1;
              end
              jph_nxt = smj_pkg::PH_SELECT;
              st_nxt  = S_SCAN;
            end else begin
              em_ln_nxt = (jph_r == smj_pkg::PH_RNULL);
              em_rn_nxt = (jph_r == smj_pkg::PH_LNULL);
              st_nxt    = S_ROW;
            end
          end
          smj_pkg::PH_TAILR: begin
            if (ic_r >= rcnt_r) begin
              if (rb_r >= rcnt_r && is_eq && lmode) begin
                oc_nxt  = lb_r;
                jph_nxt = smj_pkg::PH_TAILL;
              end else begin
                jph_nxt = smj_pkg::PH_DONE;
              end
            end else begin
              em_ln_nxt = 1'b1;
              st_nxt    = S_ROW;
            end
          end
          smj_pkg::PH_TAILL: begin
            if (oc_r >= lcnt_r) begin
              jph_nxt = smj_pkg::PH_DONE;
            end else begin
              em_rn_nxt = 1'b1;
              st_nxt    = S_ROW;
            end
          end
          default: begin
            em_end_nxt = 1'b1;
            st_nxt     = S_ROW;
          end
        endcase
      end
      S_SCAN: begin
        if (!scan_l_r && !scan_r_r) begin
          st_nxt = S_EVAL;
        end else if (s_beg >= s_cnt) begin
          if (scan_l_r) begin
            ls_nxt = s_beg;
            scan_l_nxt = 1'b0;
          end else begin
            rs_nxt = s_beg;
            scan_r_nxt = 1'b0;
          end
        end else begin
          e_nxt  = s_beg + ONE_C;
          st_nxt = S_K0;
        end
      end
      S_K0: begin
        if (scan_l_r) begin
          lk_nxt = s_rkey;
        end else begin
          rk_nxt = s_rkey;
        end
        st_nxt = S_CHK;
      end
      S_CHK: begin
        if (e_r >= s_cnt) begin
          if (scan_l_r) begin
            ls_nxt = e_r;
            scan_l_nxt = 1'b0;
          end else begin
            rs_nxt = e_r;
            scan_r_nxt = 1'b0;
          end
          st_nxt = S_SCAN;
        end else begin
          st_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (s_rkey == s_key) begin
          e_nxt  = e_r + ONE_C;
          st_nxt = S_CHK;
        end else begin
          if (scan_l_r) begin
            ls_nxt = e_r;
            scan_l_nxt = 1'b0;
          end else begin
            rs_nxt = e_r;
            scan_r_nxt = 1'b0;
          end
          st_nxt = S_SCAN;
        end
      end
      S_ROW: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tlast_nxt  = em_end_r;
          out_tdata_nxt  = '0;
          out_tdata_nxt[65] = em_rn_r;
          out_tdata_nxt[32] = em_ln_r;
          if (!em_ln_r && !em_end_r) begin
            out_tdata_nxt[31:0] = smj_pkg::OUT_ROW_W'(l_rdata[KEY_BITS +: ROW_BITS]);
          end
          if (!em_rn_r && !em_end_r) begin
            out_tdata_nxt[64:33] = smj_pkg::OUT_ROW_W'(r_rdata[KEY_BITS +: ROW_BITS]);
          end
          case (jph_r)
            smj_pkg::PH_CROSS: begin
              if (ic_r + ONE_C >= c_ib) begin
                ic_nxt = c_ia;
                oc_nxt = oc_r + ONE_C;
              end else begin
                ic_nxt = ic_r + ONE_C;
              end
            end
            smj_pkg::PH_LNULL, smj_pkg::PH_TAILL: oc_nxt = oc_r + ONE_C;
            smj_pkg::PH_RNULL, smj_pkg::PH_TAILR: ic_nxt = ic_r + ONE_C;
            default: jph_nxt = smj_pkg::PH_DONE;
          endcase
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      jph_r <= smj_pkg::PH_IDLE;
      cmp_r <= smj_pkg::CMP_EQ;
      mode_r <= smj_pkg::MODE_INNER;
      lcnt_r <= '0;  rcnt_r <= '0;
      lb_r <= '0;  ls_r <= '0;  rb_r <= '0;  rs_r <= '0;
      oc_r <= '0;  ic_r <= '0;  e_r <= '0;
      scan_l_r <= 1'b0;  scan_r_r <= 1'b0;
      em_ln_r <= 1'b0;  em_rn_r <= 1'b0;  em_end_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      jph_r <= jph_nxt;
      lcnt_r <= lcnt_nxt;  rcnt_r <= rcnt_nxt;
      lb_r <= lb_nxt;  ls_r <= ls_nxt;  rb_r <= rb_nxt;  rs_r <= rs_nxt;
      oc_r <= oc_nxt;  ic_r <= ic_nxt;  e_r <= e_nxt;
      scan_l_r <= scan_l_nxt;  scan_r_r <= scan_r_nxt;
      em_ln_r <= em_ln_nxt;  em_rn_r <= em_rn_nxt;  em_end_r <= em_end_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wen && cfg_index == smj_pkg::REG_COMPARE_OP) begin
        cmp_r <= cfg_data;
      end
      if (cfg_wen && cfg_index == smj_pkg::REG_JOIN_MODE) begin
        mode_r <= cfg_data[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    lk_r <= lk_nxt;
    rk_r <= rk_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

endmodule

### design/smj_checker.sv
// Port-level checker for the sort-merge join engine, bound to the top level.
// Uses no package.
module smj_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tlast
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("Result transaction changed while stalled.");

  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == '0)
    else $error("End of join carries nonzero fields.");

  a_one_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[32] && out_tdata[65]))
    else $error("Both sides marked null.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Result valid right after reset.");

endmodule

bind sort_merge_join_engine smj_checker u_smj_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tlast(out_tlast)
);

### verif/tb_sort_merge_join_engine.sv
// Self-checking testbench for sort_merge_join_engine: loads key-sorted tables,
// fetches joined pairs under every predicate and join mode, and checks each pair
// against an internal join predictor. Depends on smj_pkg and the engine RTL.
module tb_sort_merge_join_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import smj_pkg::*;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] row;
    logic [31:0] key;
  } cmd_t;

  typedef struct packed {
    logic [31:0] lrow;
    logic        lnull;
    logic [31:0] rrow;
    logic        rnull;
    logic        last;
  } pair_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [71:0] out_tdata;
  logic        out_tlast;
  logic        cfg_wen = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  sort_merge_join_engine uut (.*);

  cmd_t  pending_cmds[$];
  pair_t expected_pairs[$];
  int    mismatches = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;

  // Predictor state.
  logic [31:0] lkeys[DEPTH];
  logic [31:0] lrows[DEPTH];
  logic [31:0] rkeys[DEPTH];
  logic [31:0] rrows[DEPTH];
  int unsigned lcnt, rcnt, lb, le, rb, re, oc, ic;
  logic [2:0] ph;
  logic [2:0] cmp_op;
  logic [1:0] jmode;

  function automatic int unsigned run_stop(bit left_side, int unsigned s, int unsigned n);
    int unsigned e;
    if (s >= n) return s;
    e = s + 1;
    while (e < n && (left_side ? lkeys[e] == lkeys[s] : rkeys[e] == rkeys[s])) e++;
    return e;
  endfunction

  function automatic void step_runs(logic signed [31:0] lv, logic signed [31:0] rv);
    if (lv <= rv) begin
      lb = le;
      le = run_stop(1, lb, lcnt);
    end
    if (lv >= rv) begin
      rb = re;
      re = run_stop(0, rb, rcnt);
    end
  endfunction

  function automatic bit pair_ranges(logic signed [31:0] lv, logic signed [31:0] rv,
                                     output int unsigned oa, output int unsigned ob,
                                     output int unsigned ia, output int unsigned ib);
    oa = lb; ob = le; ia = rb; ib = re;
    case (cmp_op)
      CMP_EQ: return lv == rv;
      CMP_LT: begin
        ib = rcnt;
        if (lv == rv) begin
          ia = re;
          return 1;
        end
        return lv < rv;
      end
      CMP_GT: begin
        ob = lcnt;
        if (lv == rv) begin
          oa = le;
          return 1;
        end
        return lv > rv;
      end
      CMP_LE: begin
        ib = rcnt;
        return lv <= rv;
      end
      CMP_GE: begin
        ob = lcnt;
        return lv >= rv;
      end
      default: return 0;
    endcase
  endfunction

  function automatic bit left_outer();
    return cmp_op == CMP_EQ && (jmode == MODE_LEFT || jmode == MODE_FULL);
  endfunction

  function automatic void go_left_tail();
    if (rb >= rcnt && left_outer()) begin
      oc = lb;
      ph = PH_TAILL;
    end else begin
      ph = PH_DONE;
    end
  endfunction

  function automatic pair_t next_pair();
    int unsigned oa, ob, ia, ib;
    logic signed [31:0] lv, rv;
    pair_t p;
    p = '0;
    forever begin
      lv = lb < DEPTH && lb < lcnt ? lkeys[lb] : 0;
      rv = rb < DEPTH && rb < rcnt ? rkeys[rb] : 0;
      case (ph)
        PH_IDLE: begin
          lb = 0; le = run_stop(1, 0, lcnt);
          rb = 0; re = run_stop(0, 0, rcnt);
          ph = PH_SELECT;
        end
        PH_SELECT: begin
          if (lb < lcnt && rb < rcnt) begin
            if (pair_ranges(lv, rv, oa, ob, ia, ib)) begin
              oc = oa; ic = ia; ph = PH_CROSS;
            end else if (lv < rv && left_outer()) begin
              oc = lb; ph = PH_LNULL;
            end else if (cmp_op == CMP_EQ && lv > rv && jmode >= MODE_RIGHT) begin
              ic = rb; ph = PH_RNULL;
            end else begin
              step_runs(lv, rv);
            end
          end else if (lb >= lcnt && cmp_op == CMP_EQ && jmode >= MODE_RIGHT) begin
            ic = rb; ph = PH_TAILR;
          end else begin
            go_left_tail();
          end
        end
        PH_CROSS: begin
          void'(pair_ranges(lv, rv, oa, ob, ia, ib));
          if (oc >= ob || ia >= ib) begin
            step_runs(lv, rv);
            ph = PH_SELECT;
          end else begin
            p.lrow = lrows[oc]; p.rrow = rrows[ic];
            ic++;
            if (ic >= ib) begin
              ic = ia; oc++;
            end
            return p;
          end
        end
        PH_LNULL: begin
          if (oc >= le) begin
            step_runs(lv, rv);
            ph = PH_SELECT;
          end else begin
            p.lrow = lrows[oc]; p.rnull = 1; oc++;
            return p;
          end
        end
        PH_RNULL: begin
          if (ic >= re) begin
            step_runs(lv, rv);
            ph = PH_SELECT;
          end else begin
            p.lnull = 1; p.rrow = rrows[ic]; ic++;
            return p;
          end
        end
        PH_TAILR: begin
          if (ic >= rcnt) begin
            go_left_tail();
          end else begin
            p.lnull = 1; p.rrow = rrows[ic]; ic++;
            return p;
          end
        end
        PH_TAILL: begin
          if (oc >= lcnt) begin
            ph = PH_DONE;
          end else begin
            p.lrow = lrows[oc]; p.rnull = 1; oc++;
            return p;
          end
        end
        default: begin
          p.last = 1;
          return p;
        end
      endcase
    end
  endfunction

  function automatic void predict(cmd_t c);
    case (c.op)
      OP_CLEAR: begin
        lcnt = 0; rcnt = 0; ph = PH_IDLE;
      end
      OP_LOAD_L: begin
        if (lcnt < DEPTH) begin
          lkeys[lcnt] = c.key; lrows[lcnt] = c.row; lcnt++;
        end
        ph = PH_IDLE;
      end
      OP_LOAD_R: begin
        if (rcnt < DEPTH) begin
          rkeys[rcnt] = c.key; rrows[rcnt] = c.row; rcnt++;
        end
        ph = PH_IDLE;
      end
      default: expected_pairs.insert(expected_pairs.size(), next_pair());
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  // Driver: each accepted transaction is predicted at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict({in_tuser, in_tdata[31:0], in_tdata[63:32]});
      if ((!in_tvalid || in_tready) && pending_cmds.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        cmd_t c;
        c = pending_cmds.pop_front();
        in_tvalid <= 1;
        in_tuser <= c.op;
        in_tdata <= {c.key, c.row};
      end else if (in_tready) begin
        in_tvalid <= 0;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        pair_t got, want;
        got = {out_tdata[31:0], out_tdata[32], out_tdata[64:33], out_tdata[65], out_tlast};
        if (expected_pairs.size() == 0) begin
          report_mismatch("pair with none expected");
        end else begin
          want = expected_pairs.pop_front();
          if (got.lrow !== want.lrow)
            report_mismatch($sformatf("left_row %h want %h", got.lrow, want.lrow));
          if (got.lnull !== want.lnull)
            report_mismatch($sformatf("left_is_null %b want %b", got.lnull, want.lnull));
          if (got.rrow !== want.rrow)
            report_mismatch($sformatf("right_row %h want %h", got.rrow, want.rrow));
          if (got.rnull !== want.rnull)
            report_mismatch($sformatf("right_is_null %b want %b", got.rnull, want.rnull));
          if (got.last !== want.last)
            report_mismatch($sformatf("end_of_join %b want %b", got.last, want.last));
        end
      end
      out_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  task automatic add_cmd(logic [1:0] op, logic [31:0] row, logic [31:0] key);
    cmd_t c;
    c.op = op; c.row = row; c.key = key;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || in_tvalid || expected_pairs.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_wen <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_wen <= 0;
    if (idx == REG_COMPARE_OP) cmp_op = val; else jmode = val[1:0];
    ph = PH_IDLE;
  endtask

  // Clears and loads two sorted tables whose keys often repeat, so runs form, then fetches.
  task automatic random_join(int nl, int nr, int span);
    int k;
    int base;
    base = $urandom_range(1) ? 0 : $urandom;
    add_cmd(OP_CLEAR, $urandom, $urandom);
    k = base;
    for (int i = 0; i < nl; i++) begin
      k += $urandom_range(2) == 0 ? $urandom_range(span) : 0;
      add_cmd(OP_LOAD_L, $urandom, k);
    end
    k = base;
    for (int i = 0; i < nr; i++) begin
      k += $urandom_range(2) == 0 ? $urandom_range(span) : 0;
      add_cmd(OP_LOAD_R, $urandom, k);
    end
    for (int i = 0; i < nl * nr / 2 + nl + nr + 2; i++) begin
      if ($urandom_range(40) == 0) add_cmd(2'($urandom_range(2)), $urandom, $urandom);
      add_cmd(OP_FETCH, $urandom, $urandom);
    end
  endtask

  initial begin
    lcnt = 0; rcnt = 0; ph = PH_IDLE; cmp_op = CMP_EQ; jmode = MODE_INNER;
    lb = 0; le = 0; rb = 0; re = 0; oc = 0; ic = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty tables, extreme keys and rows, fetch past the end.
    add_cmd(OP_FETCH, 0, 0);
    add_cmd(OP_LOAD_L, 32'hFFFF_FFFF, 32'h8000_0000);
    add_cmd(OP_LOAD_L, 32'h0, 32'h8000_0000);
    add_cmd(OP_LOAD_L, 32'h5555_AAAA, 32'h7FFF_FFFF);
    add_cmd(OP_LOAD_R, 32'hAAAA_5555, 32'h8000_0000);
    add_cmd(OP_LOAD_R, 32'h1234_5678, 32'h0);
    add_cmd(OP_LOAD_R, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    repeat (8) add_cmd(OP_FETCH, 0, 0);
    add_cmd(OP_LOAD_L, 7, 32'h7FFF_FFFF);
    repeat (5) add_cmd(OP_FETCH, $urandom, $urandom);
    drain();

    // Each idling phase covers two predicate codes and one join mode of the equi join.
    for (int ph_i = 0; ph_i < 4; ph_i++) begin
      send_idle_pct = ph_i == 1 ? 73 : ph_i == 3 ? 12 : 0;
      recv_stall_pct = ph_i == 2 ? 73 : ph_i == 3 ? 12 : 0;
      for (int k = 0; k < 2; k++) begin
        write_reg(REG_COMPARE_OP, CFG_W'(ph_i + 4 * k));
        write_reg(REG_JOIN_MODE, CFG_W'($urandom_range(3)));
        random_join($urandom_range(3), $urandom_range(3), $urandom_range(1) ? 2 : 32'hFFFF);
        drain();
      end
      write_reg(REG_COMPARE_OP, CMP_EQ);
      write_reg(REG_JOIN_MODE, CFG_W'(ph_i));
      random_join($urandom_range(1, 4), $urandom_range(4), 2);
      random_join($urandom_range(1, 2), 0, 3);
      drain();
    end

    // Table-full case: overflow the left table by a few rows.
    send_idle_pct = 0; recv_stall_pct = 0;
    write_reg(REG_COMPARE_OP, CMP_EQ);
    write_reg(REG_JOIN_MODE, CFG_W'(MODE_FULL));
    add_cmd(OP_CLEAR, 0, 0);
    for (int i = 0; i < DEPTH + 3; i++) add_cmd(OP_LOAD_L, $urandom, i);
    add_cmd(OP_LOAD_R, 5, DEPTH);
    add_cmd(OP_LOAD_R, 6, DEPTH - 1);
    repeat (8) add_cmd(OP_FETCH, 0, 0);
    drain();

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
